FILE: hdl/lkbt_pkg.sv
package lkbt_pkg;

    // Default sizes of the grid axes and of the layer stack
    localparam int VAR_POINTS_DEF  = 64;
    localparam int CORR_POINTS_DEF = 64;
    localparam int MAX_LAYERS_DEF  = 16;

    // Kernel grid store: fixed by the 12-bit table index
    localparam int GRID_DEPTH = 4096;
    localparam int GRID_AW    = 12;

    // One iteration per quotient bit of (cov << 16) / var
    localparam int DIV_STEPS = 48;
    localparam int DIV_CNT_W = 6;

    typedef enum logic [1:0] {
        CMD_LOAD_GRID = 2'd0,
        CMD_LOAD_VAR  = 2'd1,
        CMD_BASELINE  = 2'd2,
        CMD_SAMPLE    = 2'd3
    } t_command;

    typedef enum logic [2:0] {
        CFG_LAYER_COUNT     = 3'd0,
        CFG_WEIGHT_VARIANCE = 3'd1,
        CFG_BIAS_VARIANCE   = 3'd2,
        CFG_VAR_ORIGIN      = 3'd3,
        CFG_VAR_INV_STEP    = 3'd4,
        CFG_CORR_ORIGIN     = 3'd5,
        CFG_CORR_INV_STEP   = 3'd6
    } t_cfg_idx;

    typedef enum logic [3:0] {
        OP_NONE     = 4'd0,
        OP_CAPTURE  = 4'd1,
        OP_MULW     = 4'd2,
        OP_ADDW     = 4'd3,
        OP_DIV_INIT = 4'd4,
        OP_DIV_STEP = 4'd5,
        OP_DIV_END  = 4'd6,
        OP_XMUL     = 4'd7,
        OP_XPOS     = 4'd8,
        OP_YMUL     = 4'd9,
        OP_YPOS     = 4'd10,
        OP_WMUL     = 4'd11,
        OP_GMUL     = 4'd12,
        OP_ACC      = 4'd13,
        OP_INTERP   = 4'd14,
        OP_OUT      = 4'd15
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] corner;
    } t_dp_ctl;

    typedef struct packed {
        logic       out_full;
        logic [4:0] layer_count;
    } t_dp_sts;

endpackage

FILE: hdl/lkbt_ram.sv
module lkbt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/lkbt_dp.sv
module lkbt_dp #(
    parameter int VAR_POINTS  = lkbt_pkg::VAR_POINTS_DEF,
    parameter int CORR_POINTS = lkbt_pkg::CORR_POINTS_DEF,
    parameter int MAX_LAYERS  = lkbt_pkg::MAX_LAYERS_DEF,
    parameter int LW          = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lkbt_pkg::t_dp_ctl   i_ctl,
    output lkbt_pkg::t_dp_sts   o_sts,
    input  logic [LW-1:0]       i_layer_idx,
    input  logic [1:0]          i_command,
    input  logic [11:0]         i_table_index,
    input  logic [31:0]         i_data_value,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic                o_result_kind,
    output logic [31:0]         o_result_value,
    output logic                o_saturated
);

    localparam int XW = $clog2(VAR_POINTS);
    localparam int YW = $clog2(CORR_POINTS);

    // configuration
    logic [4:0]         r_layer_count;
    logic [30:0]        r_weight;
    logic [30:0]        r_bias;
    logic signed [31:0] r_var_org;
    logic [30:0]        r_var_inv;
    logic signed [31:0] r_corr_org;
    logic [30:0]        r_corr_inv;

    // working state
    logic signed [31:0] r_cov;
    logic signed [31:0] r_var;
    logic signed [31:0] r_corr;
    logic signed [31:0] r_base;
    logic               r_kind;
    logic               r_flag;
    logic signed [67:0] r_prod;
    logic signed [63:0] r_acc;
    logic [31:0]        r_rem;
    logic [47:0]        r_quo;
    logic [31:0]        r_div;
    logic               r_neg;
    logic [XW-1:0]      r_x0;
    logic [YW-1:0]      r_y0;
    logic [15:0]        r_fx;
    logic [15:0]        r_fy;
    logic               r_xcl;
    logic               r_ycl;

    // result register
    logic               r_out_valid;
    logic               r_out_kind;
    logic [31:0]        r_out_value;
    logic               r_out_sat;

    logic [31:0]        grid_rdata;
    logic [31:0]        var_rdata;
    logic               grid_we;
    logic               var_we;
    logic [lkbt_pkg::GRID_AW-1:0] grid_addr;
    logic [lkbt_pkg::GRID_AW-1:0] corner_addr;
    logic [LW-1:0]      var_addr;

    logic signed [33:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [32:0] diff_x;
    logic signed [32:0] diff_y;
    logic [XW-1:0]      row;
    logic [YW-1:0]      col;
    logic [16:0]        wx;
    logic [16:0]        wy;
    logic [35:0]        pos_idx;
    logic               pos_clamp;
    logic [32:0]        div_t;
    logic               div_ge;
    logic [32:0]        addw_sat;
    logic [32:0]        fin_sat;
    logic signed [67:0] addw_v;
    logic signed [63:0] interp_sum;

    function automatic logic [32:0] sat32(input logic signed [67:0] v);
        if (v > 68'sd2147483647) begin
            return {1'b1, 32'h7fff_ffff};
        end else if (v < -68'sd2147483648) begin
            return {1'b1, 32'h8000_0000};
        end
        return {1'b0, v[31:0]};
    endfunction

    // RAM ports: the write of a load item wins the address
    assign grid_we  = (i_ctl.op == lkbt_pkg::OP_CAPTURE) &&
                      (i_command == lkbt_pkg::CMD_LOAD_GRID);
    assign var_we   = (i_ctl.op == lkbt_pkg::OP_CAPTURE) &&
                      (i_command == lkbt_pkg::CMD_LOAD_VAR) &&
                      (32'(i_table_index) < 32'(MAX_LAYERS));
    assign grid_addr = grid_we ? i_table_index : corner_addr;
    assign var_addr  = var_we ? i_table_index[LW-1:0] : i_layer_idx;

    lkbt_ram #(.WIDTH(32), .DEPTH(lkbt_pkg::GRID_DEPTH)) u_grid (
        .i_clk   (i_clk),
        .i_we    (grid_we),
        .i_addr  (grid_addr),
        .i_wdata (i_data_value),
        .o_rdata (grid_rdata)
    );

    lkbt_ram #(.WIDTH(32), .DEPTH(2 ** LW)) u_var (
        .i_clk   (i_clk),
        .i_we    (var_we),
        .i_addr  (var_addr),
        .i_wdata (i_data_value),
        .o_rdata (var_rdata)
    );

    // corner selection: bit 1 picks the upper variance row, bit 0 the upper column
    assign row = i_ctl.corner[1] ? (r_xcl ? r_x0 : r_x0 + XW'(1)) : r_x0;
    assign col = i_ctl.corner[0] ? (r_ycl ? r_y0 : r_y0 + YW'(1)) : r_y0;
    assign wx  = i_ctl.corner[1] ? {1'b0, r_fx} : 17'h10000 - {1'b0, r_fx};
    assign wy  = i_ctl.corner[0] ? {1'b0, r_fy} : 17'h10000 - {1'b0, r_fy};
    assign corner_addr = lkbt_pkg::GRID_AW'(32'(row) * 32'(CORR_POINTS) + 32'(col));

    assign diff_x = 33'(r_var) - 33'(r_var_org);
    assign diff_y = 33'(r_corr) - 33'(r_corr_org);

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_ctl.op)
            lkbt_pkg::OP_MULW: begin
                mul_a = 34'(r_cov);
                mul_b = $signed({3'b0, r_weight});
            end
            lkbt_pkg::OP_XMUL: begin
                mul_a = (diff_x > 0) ? 34'(diff_x) : '0;
                mul_b = $signed({3'b0, r_var_inv});
            end
            lkbt_pkg::OP_YMUL: begin
                mul_a = (diff_y > 0) ? 34'(diff_y) : '0;
                mul_b = $signed({3'b0, r_corr_inv});
            end
            lkbt_pkg::OP_WMUL: begin
                mul_a = $signed({17'b0, wx});
                mul_b = $signed({17'b0, wy});
            end
            lkbt_pkg::OP_GMUL: begin
                mul_a = 34'($signed(grid_rdata));
                mul_b = $signed({1'b0, r_prod[32:0]});
            end
            default: begin
            end
        endcase
    end

    assign pos_idx   = r_prod[67:32];
    assign div_t     = {r_rem, r_quo[47]};
    assign div_ge    = div_t >= {1'b0, r_div};
    assign addw_v    = ((r_prod + 68'sd32768) >>> 16) + $signed({37'b0, r_bias});
    assign addw_sat  = sat32(addw_v);
    assign fin_sat   = sat32(68'(r_cov) - 68'(r_base));
    assign interp_sum = r_acc + 64'sd2147483648;

    always_comb begin
        if (i_ctl.op == lkbt_pkg::OP_XPOS) begin
            pos_clamp = pos_idx >= 36'(VAR_POINTS - 1);
        end else begin
            pos_clamp = pos_idx >= 36'(CORR_POINTS - 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layer_count <= '0;
            r_weight      <= 31'h10000;
            r_bias        <= '0;
            r_var_org     <= '0;
            r_var_inv     <= 31'h10000;
            r_corr_org    <= -32'sd65536;
            r_corr_inv    <= 31'h10000;
            r_base        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    lkbt_pkg::CFG_LAYER_COUNT:     r_layer_count <= i_cfg_data[4:0];
                    lkbt_pkg::CFG_WEIGHT_VARIANCE: r_weight      <= i_cfg_data[30:0];
                    lkbt_pkg::CFG_BIAS_VARIANCE:   r_bias        <= i_cfg_data[30:0];
                    lkbt_pkg::CFG_VAR_ORIGIN:      r_var_org     <= i_cfg_data;
                    lkbt_pkg::CFG_VAR_INV_STEP:    r_var_inv     <= i_cfg_data[30:0];
                    lkbt_pkg::CFG_CORR_ORIGIN:     r_corr_org    <= i_cfg_data;
                    lkbt_pkg::CFG_CORR_INV_STEP:   r_corr_inv    <= i_cfg_data[30:0];
                    default: begin
                    end
                endcase
            end
            if (i_ctl.op == lkbt_pkg::OP_OUT) begin
                r_out_valid <= 1'b1;
                if (!r_kind) begin
                    r_base <= r_cov;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (i_ctl.op)
            lkbt_pkg::OP_CAPTURE: begin
                r_kind <= (i_command == lkbt_pkg::CMD_SAMPLE);
                r_flag <= 1'b0;
                r_cov  <= (i_command == lkbt_pkg::CMD_SAMPLE) ? i_data_value
                                                               : {1'b0, r_bias};
            end
            lkbt_pkg::OP_ADDW: begin
                r_cov  <= addw_sat[31:0];
                r_flag <= r_flag | addw_sat[32];
            end
            lkbt_pkg::OP_DIV_INIT: begin
                r_var <= var_rdata;
                r_div <= var_rdata[31] ? 32'(0) - var_rdata : var_rdata;
                r_quo <= {(r_cov[31] ? 32'(0) - r_cov : r_cov), 16'b0};
                r_rem <= '0;
                r_neg <= r_cov[31] ^ var_rdata[31];
                r_acc <= '0;
            end
            lkbt_pkg::OP_DIV_STEP: begin
                r_rem <= div_ge ? 32'(div_t - {1'b0, r_div}) : div_t[31:0];
                r_quo <= {r_quo[46:0], div_ge};
            end
            lkbt_pkg::OP_DIV_END: begin
                if (r_var == '0) begin
                    // zero variance: saturate with the sign of the covariance
                    r_flag <= 1'b1;
                    r_corr <= r_cov[31] ? 32'h8000_0000 : 32'h7fff_ffff;
                end else if (r_neg) begin
                    if (r_quo > 48'h8000_0000) begin
                        r_flag <= 1'b1;
                        r_corr <= 32'h8000_0000;
                    end else begin
                        r_corr <= 32'(0) - r_quo[31:0];
                    end
                end else if (r_quo > 48'h7fff_ffff) begin
                    r_flag <= 1'b1;
                    r_corr <= 32'h7fff_ffff;
                end else begin
                    r_corr <= r_quo[31:0];
                end
            end
            lkbt_pkg::OP_XPOS: begin
                r_xcl <= pos_clamp;
                r_x0  <= pos_clamp ? XW'(VAR_POINTS - 1) : pos_idx[XW-1:0];
                r_fx  <= pos_clamp ? 16'b0 : r_prod[31:16];
            end
            lkbt_pkg::OP_YPOS: begin
                r_ycl <= pos_clamp;
                r_y0  <= pos_clamp ? YW'(CORR_POINTS - 1) : pos_idx[YW-1:0];
                r_fy  <= pos_clamp ? 16'b0 : r_prod[31:16];
            end
            lkbt_pkg::OP_ACC: begin
                r_acc <= r_acc + r_prod[63:0];
            end
            lkbt_pkg::OP_INTERP: begin
                r_cov <= interp_sum[63:32];
            end
            lkbt_pkg::OP_OUT: begin
                r_out_kind  <= r_kind;
                r_out_value <= r_kind ? fin_sat[31:0] : r_cov;
                r_out_sat   <= r_flag | (r_kind & fin_sat[32]);
            end
            default: begin
            end
        endcase
    end

    assign o_sts.out_full    = r_out_valid & ~i_out_ready;
    assign o_sts.layer_count = r_layer_count;
    assign o_out_valid    = r_out_valid;
    assign o_result_kind  = r_out_kind;
    assign o_result_value = r_out_value;
    assign o_saturated    = r_out_sat;

endmodule

FILE: hdl/lkbt_ctrl.sv
module lkbt_ctrl #(
    parameter int MAX_LAYERS = lkbt_pkg::MAX_LAYERS_DEF,
    parameter int LW         = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic [1:0]         i_command,
    output logic               o_in_ready,
    input  lkbt_pkg::t_dp_sts  i_sts,
    output lkbt_pkg::t_dp_ctl  o_ctl,
    output logic [LW-1:0]      o_layer_idx
);

    localparam int LCW = $clog2(MAX_LAYERS + 1);

    typedef enum logic [15:0] {
        S_IDLE   = 16'h0001,
        S_MULW   = 16'h0002,
        S_ADDW   = 16'h0004,
        S_LCHK   = 16'h0008,
        S_DINIT  = 16'h0010,
        S_DSTEP  = 16'h0020,
        S_DEND   = 16'h0040,
        S_XMUL   = 16'h0080,
        S_XPOS   = 16'h0100,
        S_YMUL   = 16'h0200,
        S_YPOS   = 16'h0400,
        S_WMUL   = 16'h0800,
        S_GMUL   = 16'h1000,
        S_ACC    = 16'h2000,
        S_INTERP = 16'h4000,
        S_OUT    = 16'h8000
    } t_state;

    t_state                        r_state, n_state;
    logic [LCW-1:0]                r_layer, n_layer;
    logic [lkbt_pkg::DIV_CNT_W-1:0] r_step, n_step;
    logic [1:0]                    r_corner, n_corner;
    logic [LCW-1:0]                layer_lim;

    assign layer_lim = (32'(i_sts.layer_count) >= 32'(MAX_LAYERS)) ?
                       LCW'(MAX_LAYERS) : LCW'(i_sts.layer_count);

    always_comb begin
        n_state      = r_state;
        n_layer      = r_layer;
        n_step       = r_step;
        n_corner     = r_corner;
        o_ctl.op     = lkbt_pkg::OP_NONE;
        o_ctl.corner = r_corner;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.op = lkbt_pkg::OP_CAPTURE;
                    n_layer  = '0;
                    if (i_command == lkbt_pkg::CMD_SAMPLE) begin
                        n_state = S_MULW;
                    end else if (i_command == lkbt_pkg::CMD_BASELINE) begin
                        n_state = S_LCHK;
                    end
                end
            end
            S_MULW: begin
                o_ctl.op = lkbt_pkg::OP_MULW;
                n_state  = S_ADDW;
            end
            S_ADDW: begin
                o_ctl.op = lkbt_pkg::OP_ADDW;
                n_state  = S_LCHK;
            end
            S_LCHK: begin
                n_state = (r_layer == layer_lim) ? S_OUT : S_DINIT;
            end
            S_DINIT: begin
                o_ctl.op = lkbt_pkg::OP_DIV_INIT;
                n_step   = '0;
                n_state  = S_DSTEP;
            end
            S_DSTEP: begin
                o_ctl.op = lkbt_pkg::OP_DIV_STEP;
                n_step   = r_step + 1'b1;
                if (r_step == lkbt_pkg::DIV_CNT_W'(lkbt_pkg::DIV_STEPS - 1)) begin
                    n_state = S_DEND;
                end
            end
            S_DEND: begin
                o_ctl.op = lkbt_pkg::OP_DIV_END;
                n_state  = S_XMUL;
            end
            S_XMUL: begin
                o_ctl.op = lkbt_pkg::OP_XMUL;
                n_state  = S_XPOS;
            end
            S_XPOS: begin
                o_ctl.op = lkbt_pkg::OP_XPOS;
                n_state  = S_YMUL;
            end
            S_YMUL: begin
                o_ctl.op = lkbt_pkg::OP_YMUL;
                n_state  = S_YPOS;
            end
            S_YPOS: begin
                o_ctl.op = lkbt_pkg::OP_YPOS;
                n_corner = '0;
                n_state  = S_WMUL;
            end
            S_WMUL: begin
                o_ctl.op = lkbt_pkg::OP_WMUL;
                n_state  = S_GMUL;
            end
            S_GMUL: begin
                o_ctl.op = lkbt_pkg::OP_GMUL;
                n_state  = S_ACC;
            end
            S_ACC: begin
                o_ctl.op = lkbt_pkg::OP_ACC;
                if (r_corner == 2'd3) begin
                    n_state = S_INTERP;
                end else begin
                    n_corner = r_corner + 1'b1;
                    n_state  = S_WMUL;
                end
            end
            S_INTERP: begin
                o_ctl.op = lkbt_pkg::OP_INTERP;
                n_layer  = r_layer + 1'b1;
                n_state  = S_MULW;
            end
            S_OUT: begin
                if (!i_sts.out_full) begin
                    o_ctl.op = lkbt_pkg::OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_layer  <= '0;
            r_step   <= '0;
            r_corner <= '0;
        end else begin
            r_state  <= n_state;
            r_layer  <= n_layer;
            r_step   <= n_step;
            r_corner <= n_corner;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_layer_idx = r_layer[LW-1:0];

endmodule

FILE: hdl/layered_kernel_bilinear_table.sv
// Load items (grid entry, layer variance) give no result. Baseline and sample items
// run L = min(layer_count, MAX_LAYERS) layers before the result register. Each layer
// runs the 48-step divider and the four grid reads through the single shared multiplier.
// One item at a time; the next item is taken while a result waits downstream.
// Synchronous active-low reset returns control and configuration to their defaults; stores are not cleared.
module layered_kernel_bilinear_table #(
    parameter int VAR_POINTS  = lkbt_pkg::VAR_POINTS_DEF,
    parameter int CORR_POINTS = lkbt_pkg::CORR_POINTS_DEF,
    parameter int MAX_LAYERS  = lkbt_pkg::MAX_LAYERS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [11:0] table_index, [43:12] data_value
    input  logic [1:0]  s_axis_tuser,   // [1:0] command
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] result_value, [32] saturated
    output logic [0:0]  m_axis_tuser,   // [0] result_kind
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int LW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;

    lkbt_pkg::t_dp_ctl ctl;
    lkbt_pkg::t_dp_sts sts;
    logic [LW-1:0]     layer_idx;
    logic              res_kind;
    logic [31:0]       res_value;
    logic              res_sat;

    // Sequencer: walks each baseline or sample item through scale, the layer loop and the result hand-off
    lkbt_ctrl #(
        .MAX_LAYERS (MAX_LAYERS),
        .LW         (LW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_command   (s_axis_tuser),
        .o_in_ready  (s_axis_tready),
        .i_sts       (sts),
        .o_ctl       (ctl),
        .o_layer_idx (layer_idx)
    );

    // Datapath: registers, stores, divider, multiplier and the result register
    lkbt_dp #(
        .VAR_POINTS  (VAR_POINTS),
        .CORR_POINTS (CORR_POINTS),
        .MAX_LAYERS  (MAX_LAYERS),
        .LW          (LW)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .o_sts          (sts),
        .i_layer_idx    (layer_idx),
        .i_command      (s_axis_tuser),
        .i_table_index  (s_axis_tdata[11:0]),
        .i_data_value   (s_axis_tdata[43:12]),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_result_kind  (res_kind),
        .o_result_value (res_value),
        .o_saturated    (res_sat)
    );

    // Pack the result item; pad bits stay zero
    assign m_axis_tdata = {7'b0, res_sat, res_value};
    assign m_axis_tuser = res_kind;

endmodule
